FILE: sv/swsfd_pkg.sv
// Shared constants and types for the sliding-window source flood detector.
`default_nettype none
package swsfd_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W       = 32;
    localparam int TIME_W       = 32;
    localparam int WIN_W        = 16;
    localparam int THR_W        = 9;
    localparam int MATCH_W      = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [ADDR_W-1:0] address;
    } t_entry;

    typedef enum logic {
        CMP_AGE,
        CMP_ADDR
    } t_cmp_op;

    typedef struct packed {
        t_cmp_op           op;
        logic [ADDR_W-1:0] key;
        logic [TIME_W-1:0] now;
        logic [WIN_W-1:0]  window;
    } t_cmp_req;

endpackage
`default_nettype wire

FILE: sv/swsfd_store.sv
// Entry memory holding the stored (address, time) pairs, registered read.
`default_nettype none
module swsfd_store (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire swsfd_pkg::t_idx   i_waddr,
    input  wire swsfd_pkg::t_entry i_wdata,
    input  wire swsfd_pkg::t_idx   i_raddr,
    output swsfd_pkg::t_entry      o_rdata
);
    import swsfd_pkg::*;

    t_entry r_mem [WINDOW_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/swsfd_cmp.sv
// Shared compare unit: age-versus-window test or address equality test.
`default_nettype none
module swsfd_cmp (
    input  wire swsfd_pkg::t_cmp_req i_req,
    input  wire swsfd_pkg::t_entry   i_entry,
    output logic                     o_hit
);
    import swsfd_pkg::*;

    logic [TIME_W-1:0] age;

    always_comb begin
        // age wraps modulo 2^32
        age = i_req.now - i_entry.arrival;
        case (i_req.op)
            CMP_AGE:  o_hit = age > TIME_W'(i_req.window);
            CMP_ADDR: o_hit = i_entry.address == i_req.key;
            default:  o_hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/sliding_window_source_flood_detector.sv
// Top level: sequencer, FIFO pointers, config registers and result register.
// One request at a time; one memory read port is walked once per expiry check and
//   once per stored entry in the match scan.
// Reset (synchronous, active low): store empty, head at slot 0, window 10, threshold 100.
//   Memory contents are not cleared; only data from occupied slots is ever used.
`default_nettype none
module sliding_window_source_flood_detector (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration write port
    input  wire                                   i_cfg_we,
    input  wire [swsfd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [swsfd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // request stream
    input  wire                                   i_s_tvalid,
    output logic                                  o_s_tready,
    // [31:0] source_address, [63:32] arrival_seconds
    input  wire [swsfd_pkg::IN_DATA_W-1:0]        i_s_tdata,
    // result stream
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    // [0] is_attack, [9:1] match_count, [15:10] zero
    output logic [swsfd_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import swsfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_EXP_RD,
        S_EXP_CHK,
        S_COUNT,
        S_DONE
    } t_state;

    // Physical slot of logical position pos counted from head.
    function automatic t_idx slot_of(input t_idx head, input t_idx pos);
        logic [IDX_W:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= (IDX_W+1)'(WINDOW_DEPTH)) begin
            s = s - (IDX_W+1)'(WINDOW_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    t_state             r_state, n_state;
    t_idx               r_head, n_head;
    t_cnt               r_count, n_count;
    t_cnt               r_pos, n_pos;
    logic               r_rd_vld, n_rd_vld;
    logic [MATCH_W-1:0] r_match, n_match;
    logic [ADDR_W-1:0]  r_key;
    logic [TIME_W-1:0]  r_now;
    logic [WIN_W-1:0]   r_window;
    logic [THR_W-1:0]   r_threshold;
    logic               r_out_vld, n_out_vld;
    logic [MATCH_W-1:0] r_out_match;
    logic               r_out_attack;

    logic     s_accept;
    logic     mem_we;
    t_idx     mem_waddr;
    t_idx     mem_raddr;
    t_entry   mem_wdata;
    t_entry   mem_rdata;
    t_cmp_req cmp_req;
    logic     cmp_hit;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    swsfd_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    swsfd_cmp u_cmp (
        .i_req   (cmp_req),
        .i_entry (mem_rdata),
        .o_hit   (cmp_hit)
    );

    always_comb begin
        cmp_req.op     = (r_state == S_EXP_CHK) ? CMP_AGE : CMP_ADDR;
        cmp_req.key    = r_key;
        cmp_req.now    = r_now;
        cmp_req.window = r_window;
    end

    // Write the new entry at the tail; the drop for a full store already happened.
    assign mem_we            = (r_state == S_APPEND);
    assign mem_waddr         = slot_of(r_head, r_count[IDX_W-1:0]);
    assign mem_wdata.address = r_key;
    assign mem_wdata.arrival = r_now;

    // Read port: head during expiry, scan position during the match count.
    assign mem_raddr = (r_state == S_EXP_RD) ? r_head : slot_of(r_head, r_pos[IDX_W-1:0]);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_rd_vld  = 1'b0;
        n_match   = r_match;
        n_out_vld = r_out_vld;

        // drop the result once taken
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    // full store: drop the oldest entry to make room
                    if (r_count == CNT_W'(WINDOW_DEPTH)) begin
                        n_head  = slot_of(r_head, t_idx'(1));
                        n_count = r_count - CNT_W'(1);
                    end
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                n_count = r_count + CNT_W'(1);
                n_state = S_EXP_RD;
            end
            S_EXP_RD: begin
                n_state = S_EXP_CHK;
            end
            S_EXP_CHK: begin
                // the new entry has age zero, so this loop always stops
                if (cmp_hit && (r_count != '0)) begin
                    n_head  = slot_of(r_head, t_idx'(1));
                    n_count = r_count - CNT_W'(1);
                    n_state = S_EXP_RD;
                end else begin
                    n_pos   = '0;
                    n_match = '0;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                // issue one read per cycle, compare the returned data in the cycle after
                if (r_pos < r_count) begin
                    n_pos    = r_pos + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld && cmp_hit && (r_match != {MATCH_W{1'b1}})) begin
                    n_match = r_match + MATCH_W'(1);
                end
                if ((r_pos == r_count) && !r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_rd_vld    <= 1'b0;
            r_match     <= '0;
            r_out_vld   <= 1'b0;
            r_window    <= WIN_W'(10);
            r_threshold <= THR_W'(100);
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_rd_vld  <= n_rd_vld;
            r_match   <= n_match;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW:    r_window    <= i_cfg_data[WIN_W-1:0];
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Payload registers: latch the request, load the result on completion.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key <= i_s_tdata[ADDR_W-1:0];
            r_now <= i_s_tdata[ADDR_W +: TIME_W];
        end
        if ((r_state == S_DONE) && (n_state == S_IDLE)) begin
            r_out_match  <= r_match;
            r_out_attack <= (r_match >= r_threshold);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_DATA_W-MATCH_W-1){1'b0}}, r_out_match, r_out_attack};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_DEPTH))
        else $error("entry count beyond depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT) |-> (r_pos <= r_count))
        else $error("scan position beyond entry count");

    a_expire_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP_CHK) |-> (r_count != '0))
        else $error("expiry check on empty store");

    a_accept_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_APPEND))
        else $error("accepted request did not enter append");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (n_state == S_IDLE)) |=> r_out_vld)
        else $error("completed request produced no result");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the sliding-window source flood detector.

module tb_top;
    import swsfd_pkg::*;

    // Cycle budget: the slowest request (all but the new entry expired one by one)
    // plus both sides idling, for about 2000 requests, taken about seven times over.
    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    // Quiet time after the last result.
    localparam int          SETTLE_CYCLES = 1000;
    // Long receiver hold-off for the back-pressure test.
    localparam int          LONG_HOLD = 3000;
    localparam int          POOL_MAX = 64;

    // Behavioral copy of the detector: a time-ordered window of recent requests,
    // plus the verdicts still owed by the block.
    class flood_scoreboard;
        typedef struct {
            logic               attack;
            logic [MATCH_W-1:0] count;
        } t_verdict;

        t_entry            recent_entries[$];
        t_verdict          expected_verdicts[$];
        logic [WIN_W-1:0]  window_limit;
        logic [THR_W-1:0]  flood_threshold;
        int unsigned       failures;

        function new();
            window_limit    = 16'd10;
            flood_threshold = 9'd100;
            failures        = 0;
        endfunction

        // Unknown indexes are ignored; data is cut to the register width.
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WINDOW:    window_limit    = data[WIN_W-1:0];
                CFG_THRESHOLD: flood_threshold = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] now);
            t_entry            fresh;
            logic [TIME_W-1:0] age;
            int unsigned       hits;
            t_verdict          verdict;
            // Append, dropping the oldest entry when the store is full.
            if (recent_entries.size() >= WINDOW_DEPTH)
                void'(recent_entries.pop_front());
            fresh.address = addr;
            fresh.arrival = now;
            recent_entries.push_back(fresh);
            // Expire from the head; ages wrap, so a future timestamp looks ancient.
            while (recent_entries.size() > 0) begin
                age = now - recent_entries[0].arrival;
                if (age > TIME_W'(window_limit))
                    void'(recent_entries.pop_front());
                else
                    break;
            end
            // Count matches, saturating at the field maximum.
            hits = 0;
            foreach (recent_entries[i]) begin
                if (recent_entries[i].address == addr && hits < (1 << MATCH_W) - 1)
                    hits++;
            end
            verdict.attack = (hits >= flood_threshold);
            verdict.count  = hits[MATCH_W-1:0];
            expected_verdicts.push_back(verdict);
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_verdict want;
            if (expected_verdicts.size() == 0) begin
                $error("result 0x%0h arrived with no request outstanding", data);
                failures++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (data[0] !== want.attack) begin
                $error("is_attack: expected %0d, got %0d", want.attack, data[0]);
                failures++;
            end
            if (data[MATCH_W:1] !== want.count) begin
                $error("match_count: expected %0d, got %0d", want.count, data[MATCH_W:1]);
                failures++;
            end
            if (data[OUT_DATA_W-1:MATCH_W+1] !== '0) begin
                $error("padding: expected 0, got 0x%0h", data[OUT_DATA_W-1:MATCH_W+1]);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;

    flood_scoreboard       flood_sb = new();
    int unsigned           cycle_count = 0;
    bit                    quiet = 1'b0;      // both sides stop idling while set
    bit                    hold_long = 1'b0;  // requests one long receiver hold-off

    sliding_window_source_flood_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),     // [31:0] source_address, [63:32] arrival_seconds
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)      // [0] is_attack, [9:1] match_count, [15:10] zero
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sliding_window_source_flood_detector verification failed");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until the block takes it.
    // Valid stays high across back-to-back requests, so it gets one assignment per edge.
    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, addr};
        do @(posedge i_clk); while (!s_tready);
        flood_sb.note_request(addr, now);
    endtask

    // Drop valid and wait until every owed result is back; the block is idle then.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (flood_sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges; mirror them into the scoreboard.
    task automatic write_config(input logic [CFG_DATA_W-1:0] window,
                                input logic [CFG_DATA_W-1:0] threshold);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW;
        cfg_data <= window;
        @(posedge i_clk);
        flood_sb.write_register(CFG_WINDOW, window);
        cfg_idx  <= CFG_THRESHOLD;
        cfg_data <= threshold;
        @(posedge i_clk);
        flood_sb.write_register(CFG_THRESHOLD, threshold);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic from a small pool of sources so that counts climb, with some
    // noise sources, occasional backward steps and occasional far jumps that flush
    // the whole window.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] window,
                             input logic [CFG_DATA_W-1:0] threshold,
                             input int pool_n, input int n_requests,
                             input int unsigned max_step, input logic [TIME_W-1:0] start,
                             input int jump_pct, input bit with_hold);
        logic [ADDR_W-1:0] pool [POOL_MAX];
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
        int                roll;
        drain_requests();
        write_config(window, threshold);
        foreach (pool[i]) pool[i] = $urandom;
        now = start;
        for (int k = 0; k < n_requests; k++) begin
            if ($urandom_range(0, 39) == 0)
                quiet = !quiet;
            if (with_hold && k == n_requests / 3)
                hold_long = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < jump_pct)
                now = now - $urandom_range(1, 1000);
            else if (roll < 2 * jump_pct)
                now = $urandom;
            else
                now = now + $urandom_range(0, max_step);
            if ($urandom_range(0, 9) == 0)
                addr = $urandom;
            else
                addr = pool[$urandom_range(0, pool_n - 1)];
            send_request(addr, now);
        end
    endtask

    // Result side: random stall before each result, a long hold-off on request,
    // then check whatever the block hands over.
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_long = 1'b0;
            end else if (!quiet) begin
                stall = $urandom_range(0, 16);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
            flood_sb.check_result(m_tdata);
        end
    end

    // Main sequence: reset, directed corners, random phases, then settle and report.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short window, low threshold: age exactly at the window stays,
        // one past it expires, time steps backward and wraps past zero.
        write_config(16'd3, 16'd2);
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0000, 32'h0000_0003);
        send_request(32'hFFFF_FFFF, 32'h0000_0004);
        send_request(32'h0000_0000, 32'h0000_0002);
        send_request(32'h8000_0001, 32'hFFFF_FFFE);
        send_request(32'hA5A5_A5A5, 32'hFFFF_FFFF);
        send_request(32'h8000_0001, 32'h0000_0001);

        // Zero window; threshold data with high bits set masks down to zero,
        // so every request is flagged.
        drain_requests();
        write_config(16'd0, 16'hFE00);
        send_request(32'h5A5A_5A5A, 32'h0000_0001);
        send_request(32'h5A5A_5A5A, 32'h0000_0001);
        send_request(32'h5A5A_5A5A, 32'h0000_0002);

        // Widest window: age of exactly 0xFFFF holds, 0x10000 expires.
        drain_requests();
        write_config(16'hFFFF, 16'd1);
        send_request(32'h1234_5678, 32'h0001_0000);
        send_request(32'h1234_5678, 32'h0001_FFFF);
        send_request(32'h1234_5678, 32'h0002_0000);

        // Random phases: window, threshold, pool, requests, step, start, jump %, hold.
        run_phase(16'd10,   16'd100,  8,  300, 2,   $urandom,       2, 1'b0);
        // One pooled source plus noise sources, nothing expires: the store fills and wraps.
        run_phase(16'hFFFF, 16'd256,  1,  300, 1,   $urandom,       0, 1'b0);
        run_phase(16'd0,    16'd1,    4,  250, 1,   $urandom,       2, 1'b0);
        run_phase(16'hFFFF, 16'd1,    64, 250, 300, 32'hFFFF_FF00,  1, 1'b0);
        // Receiver holds off for a long stretch while requests keep coming.
        run_phase(16'd100,  16'd20,   3,  300, 5,   $urandom,       3, 1'b1);
        run_phase(16'd1,    16'hFE03, 2,  250, 1,   $urandom,       2, 1'b0);
        run_phase(16'd300,  16'd50,   16, 300, 4,   $urandom,       1, 1'b0);

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (flood_sb.failures == 0 && flood_sb.pending() == 0) begin
            $display("sliding_window_source_flood_detector verification clean");
        end else begin
            $display("sliding_window_source_flood_detector verification failed");
        end
        $finish;
    end

endmodule
